[design/fhcc_pkg.sv]
// Shared types, constants and register codes for the front hit containment check.
package fhcc_pkg;

    // Sizes
    localparam int FRONT_DEPTH_DEF = 8;
    localparam int POS_W           = 20;
    localparam int RAD_W           = 19;
    localparam int VIEW_W          = 3;
    localparam int HELD_W          = 5;
    localparam int HELD_MAX        = 31;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 20;
    localparam int IN_DATA_W       = 48;
    localparam int OUT_DATA_W      = 8;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_NEAR_DET = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_Z_BEGIN  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_Z_END    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_R_INNER  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_R_OUTER  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_U_CENTER = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_V_CENTER = 3'd6;

    // Reset values of the configuration registers
    localparam logic                    RST_NEAR_DET = 1'b1;
    localparam logic signed [POS_W-1:0] RST_Z_BEGIN  = 20'sd102;
    localparam logic signed [POS_W-1:0] RST_Z_END    = 20'sd7168;
    localparam logic [RAD_W-1:0]        RST_R_INNER  = 19'd0;
    localparam logic [RAD_W-1:0]        RST_R_OUTER  = 19'd1024;
    localparam logic signed [POS_W-1:0] RST_U_CENTER = 20'sd1179;
    localparam logic signed [POS_W-1:0] RST_V_CENTER = -20'sd977;

    // Item kinds and kept views
    localparam logic              ACT_HIT = 1'b0;
    localparam logic              ACT_EOE = 1'b1;
    localparam logic [VIEW_W-1:0] VIEW_U  = 3'd2;
    localparam logic [VIEW_W-1:0] VIEW_V  = 3'd3;

    // One stored front hit
    typedef struct packed {
        logic                    valid;
        logic signed [POS_W-1:0] z;
        logic signed [POS_W-1:0] t;
    } entry_t;

    // Window bounds seen by every cell of one view
    typedef struct packed {
        logic signed [POS_W-1:0] z_begin;
        logic signed [POS_W-1:0] z_end;
        logic [RAD_W-1:0]        r_inner;
        logic [RAD_W-1:0]        r_outer;
        logic signed [POS_W-1:0] center;
    } check_cfg_t;

    // Per-view control from the top level
    typedef struct packed {
        logic                    hit_en;
        logic                    clear;
        logic signed [POS_W-1:0] new_z;
        logic signed [POS_W-1:0] new_t;
    } cell_ctl_t;

endpackage

[design/fhcc_cell.sv]
// One slot of a sorted front hit list: insert, shift from neighbor, window test.
module fhcc_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  fhcc_pkg::cell_ctl_t ctl,
    input  fhcc_pkg::check_cfg_t cfg,
    input  fhcc_pkg::entry_t    prev_entry,
    input  logic                prev_ins,
    output fhcc_pkg::entry_t    entry,
    output logic                ins,
    output logic                ok
);

    logic                           valid_reg;
    logic                           valid_next;
    logic signed [fhcc_pkg::POS_W-1:0] z_reg;
    logic signed [fhcc_pkg::POS_W-1:0] z_next;
    logic signed [fhcc_pkg::POS_W-1:0] t_reg;
    logic signed [fhcc_pkg::POS_W-1:0] t_next;
    logic                           ok_reg;
    logic                           ok_next;
    logic signed [fhcc_pkg::POS_W:0] dt;
    logic [fhcc_pkg::POS_W:0]        mag;
    logic                           z_pass;
    logic                           r_pass;

    // New hit belongs at or before this slot (ties go ahead)
    assign ins = !valid_reg || (z_reg >= ctl.new_z);

    // Load new hit at the first insert slot; later slots shift from the neighbor ahead
    always_comb
    begin
        valid_next = valid_reg;
        z_next     = z_reg;
        t_next     = t_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.hit_en && prev_ins)
        begin
            valid_next = prev_entry.valid;
            z_next     = prev_entry.z;
            t_next     = prev_entry.t;
        end
        else if (ctl.hit_en && ins)
        begin
            valid_next = 1'b1;
            z_next     = ctl.new_z;
            t_next     = ctl.new_t;
        end
    end

    // Window test on the held hit
    always_comb
    begin
        dt      = {t_reg[fhcc_pkg::POS_W-1], t_reg} - {cfg.center[fhcc_pkg::POS_W-1], cfg.center};
        mag     = dt[fhcc_pkg::POS_W] ? $unsigned(-dt) : $unsigned(dt);
        z_pass  = (z_reg >= cfg.z_begin) && (z_reg <= cfg.z_end);
        r_pass  = (mag >= {2'b00, cfg.r_inner}) && (mag <= {2'b00, cfg.r_outer});
        ok_next = !valid_reg || (z_pass && r_pass);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ok_reg    <= 1'b1;
        end
        else
        begin
            valid_reg <= valid_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg <= z_next;
        t_reg <= t_next;
    end

    assign entry = '{valid: valid_reg, z: z_reg, t: t_reg};
    assign ok    = ok_reg;

endmodule

[design/fhcc_view.sv]
// Chain of cells holding the sorted front hits of one view, with fill count.
module fhcc_view
#(
    parameter int FRONT_DEPTH = fhcc_pkg::FRONT_DEPTH_DEF,
    parameter int CNT_W       = $clog2(FRONT_DEPTH + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fhcc_pkg::cell_ctl_t  ctl,
    input  fhcc_pkg::check_cfg_t cfg,
    output logic                 all_ok,
    output logic [CNT_W-1:0]     count
);

    fhcc_pkg::entry_t       chain [FRONT_DEPTH];
    logic [FRONT_DEPTH-1:0] ins_vec;
    logic [FRONT_DEPTH-1:0] ok_vec;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    // Row of cells, each fed by the one ahead of it
    for (genvar k = 0; k < FRONT_DEPTH; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            fhcc_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .cfg        (cfg),
                .prev_entry ('0),
                .prev_ins   (1'b0),
                .entry      (chain[k]),
                .ins        (ins_vec[k]),
                .ok         (ok_vec[k])
            );
        end
        else
        begin : g_body
            fhcc_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .cfg        (cfg),
                .prev_entry (chain[k-1]),
                .prev_ins   (ins_vec[k-1]),
                .entry      (chain[k]),
                .ins        (ins_vec[k]),
                .ok         (ok_vec[k])
            );
        end
    end

    // Count grows when a hit goes in and the tail slot was still empty
    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.hit_en && ins_vec[FRONT_DEPTH-1] && !chain[FRONT_DEPTH-1].valid)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign all_ok = &ok_vec;
    assign count  = count_reg;

endmodule

[design/front_hit_containment_check_core.sv]
// Top level of the front hit containment check: config, control FSM, output register.
//
//  channel  | direction | transfer holds
//  ---------+-----------+------------------------------------------------
//  s_axis   | in        | tuser: action; tdata: view, hit_z, hit_t
//  m_axis   | out       | tdata: contained, hits_held
//  cfg      | in        | cfg_we, cfg_addr (register index), cfg_data
//
//  Hits are accepted back to back while the FSM is idle.
//  An end-of-event item steps through accept, window test register, and
//  verdict and list clear, which waits for the output register to free up.
//  Reset clears the lists, the counts, the FSM and the output valid.
//  Hits are taken while a result waits on m_axis; a second check waits for it.
module front_hit_containment_check_core
#(
    parameter int FRONT_DEPTH = fhcc_pkg::FRONT_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fhcc_pkg::IN_DATA_W-1:0]    s_tdata,   // view[2:0], hit_z[22:3], hit_t[42:23]
    input  logic                              s_tuser,   // action[0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fhcc_pkg::OUT_DATA_W-1:0]   m_tdata,   // contained[0], hits_held[5:1]
    input  logic                              cfg_we,
    input  logic [fhcc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [fhcc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CNT_W  = $clog2(FRONT_DEPTH + 1);
    localparam int SUM_W  = (CNT_W + 1 > fhcc_pkg::HELD_W) ? CNT_W + 1 : fhcc_pkg::HELD_W;
    localparam int Z_LSB  = fhcc_pkg::VIEW_W;
    localparam int T_LSB  = fhcc_pkg::VIEW_W + fhcc_pkg::POS_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_DONE  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic                                 near_det_reg;
    logic signed [fhcc_pkg::POS_W-1:0]    z_begin_reg;
    logic signed [fhcc_pkg::POS_W-1:0]    z_end_reg;
    logic [fhcc_pkg::RAD_W-1:0]           r_inner_reg;
    logic [fhcc_pkg::RAD_W-1:0]           r_outer_reg;
    logic signed [fhcc_pkg::POS_W-1:0]    u_center_reg;
    logic signed [fhcc_pkg::POS_W-1:0]    v_center_reg;

    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic [fhcc_pkg::OUT_DATA_W-1:0]      out_data_reg;
    logic [fhcc_pkg::OUT_DATA_W-1:0]      out_data_next;

    logic [fhcc_pkg::VIEW_W-1:0]          in_view;
    logic                                 in_acc;
    logic                                 hit_acc;
    logic                                 out_load;
    logic                                 list_clear;
    fhcc_pkg::cell_ctl_t                  ctl_u;
    fhcc_pkg::cell_ctl_t                  ctl_v;
    fhcc_pkg::check_cfg_t                 cfg_u;
    fhcc_pkg::check_cfg_t                 cfg_v;
    logic                                 ok_u;
    logic                                 ok_v;
    logic [CNT_W-1:0]                     cnt_u;
    logic [CNT_W-1:0]                     cnt_v;
    logic [SUM_W-1:0]                     held_sum;
    logic [fhcc_pkg::HELD_W-1:0]          held;
    logic                                 verdict;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_det_reg <= fhcc_pkg::RST_NEAR_DET;
            z_begin_reg  <= fhcc_pkg::RST_Z_BEGIN;
            z_end_reg    <= fhcc_pkg::RST_Z_END;
            r_inner_reg  <= fhcc_pkg::RST_R_INNER;
            r_outer_reg  <= fhcc_pkg::RST_R_OUTER;
            u_center_reg <= fhcc_pkg::RST_U_CENTER;
            v_center_reg <= fhcc_pkg::RST_V_CENTER;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                fhcc_pkg::REG_NEAR_DET: near_det_reg <= cfg_data[0];
                fhcc_pkg::REG_Z_BEGIN:  z_begin_reg  <= cfg_data;
                fhcc_pkg::REG_Z_END:    z_end_reg    <= cfg_data;
                fhcc_pkg::REG_R_INNER:  r_inner_reg  <= cfg_data[fhcc_pkg::RAD_W-1:0];
                fhcc_pkg::REG_R_OUTER:  r_outer_reg  <= cfg_data[fhcc_pkg::RAD_W-1:0];
                fhcc_pkg::REG_U_CENTER: u_center_reg <= cfg_data;
                fhcc_pkg::REG_V_CENTER: v_center_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input transfer decode
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_view  = s_tdata[fhcc_pkg::VIEW_W-1:0];
    assign hit_acc  = in_acc && (s_tuser == fhcc_pkg::ACT_HIT);

    // Output register frees up when empty or being taken
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign list_clear = out_load;

    always_comb
    begin
        ctl_u.hit_en = hit_acc && (in_view == fhcc_pkg::VIEW_U);
        ctl_u.clear  = list_clear;
        ctl_u.new_z  = s_tdata[Z_LSB +: fhcc_pkg::POS_W];
        ctl_u.new_t  = s_tdata[T_LSB +: fhcc_pkg::POS_W];
        ctl_v        = ctl_u;
        ctl_v.hit_en = hit_acc && (in_view == fhcc_pkg::VIEW_V);

        cfg_u.z_begin = z_begin_reg;
        cfg_u.z_end   = z_end_reg;
        cfg_u.r_inner = r_inner_reg;
        cfg_u.r_outer = r_outer_reg;
        cfg_u.center  = u_center_reg;
        cfg_v         = cfg_u;
        cfg_v.center  = v_center_reg;
    end

    fhcc_view #(.FRONT_DEPTH(FRONT_DEPTH), .CNT_W(CNT_W)) u_view_u
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_u),
        .cfg    (cfg_u),
        .all_ok (ok_u),
        .count  (cnt_u)
    );

    fhcc_view #(.FRONT_DEPTH(FRONT_DEPTH), .CNT_W(CNT_W)) u_view_v
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_v),
        .cfg    (cfg_v),
        .all_ok (ok_v),
        .count  (cnt_v)
    );

    // Verdict and saturated hit count
    always_comb
    begin
        held_sum = SUM_W'(cnt_u) + SUM_W'(cnt_v);
        held     = (held_sum > SUM_W'(fhcc_pkg::HELD_MAX)) ?
                   fhcc_pkg::HELD_W'(fhcc_pkg::HELD_MAX) : held_sum[fhcc_pkg::HELD_W-1:0];
        verdict  = !near_det_reg || (ok_u && ok_v);
    end

    // Check sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (s_tuser == fhcc_pkg::ACT_EOE))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{(fhcc_pkg::OUT_DATA_W - fhcc_pkg::HELD_W - 1){1'b0}}, held, verdict};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Checks
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid)
        else $error("result load did not raise m_tvalid");

    a_check_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |=> (state_reg == ST_DONE))
        else $error("check step did not advance to verdict");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_u <= CNT_W'(FRONT_DEPTH)) && (cnt_v <= CNT_W'(FRONT_DEPTH)))
        else $error("view fill count exceeds list depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        list_clear |=> (cnt_u == '0) && (cnt_v == '0))
        else $error("lists not empty after end of event");

endmodule
